FILE: hdl/weighted_frame_blend_decimator_defines.svh
// Assertion macros used by the checker file of the frame blend decimator.
`ifndef WEIGHTED_FRAME_BLEND_DECIMATOR_DEFINES_SVH
`define WEIGHTED_FRAME_BLEND_DECIMATOR_DEFINES_SVH

// Concurrent check on the rising clock edge, switched off while reset is high
`define WFBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent check on the rising clock edge that also holds across reset
`define WFBD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/wfbd_pkg.sv
// Shared widths, register codes and word types of the frame blend decimator.
package wfbd_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int CFG_W       = 8;
  localparam int SUM_W       = 17;
  localparam int FRAME_BYTES = 65536;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int DIVISOR_W   = 9;
  localparam int QUO_W       = 8;
  localparam int DIV_STAGES  = 4;
  localparam int STEP_BITS   = QUO_W / DIV_STAGES;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Register index, taken from address bit 2
  localparam logic REG_LAPSE  = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] LAPSE_RESET  = 8'd2;
  localparam logic [CFG_W-1:0] WEIGHT_RESET = 8'd1;
  localparam logic [CFG_W-1:0] MIN_GROUP    = 8'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] blended;
    logic                out_frame_end;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] lapse_factor;
    logic [CFG_W-1:0] primary_weight;
  } cfg_t;

  // Weighted sum handed from the accumulator to the divider
  typedef struct packed {
    logic [SUM_W-1:0]     total;
    logic [DIVISOR_W-1:0] divisor;
    logic                 frame_end;
  } blend_job_t;

endpackage

FILE: hdl/wfbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port returning the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/wfbd_accum.sv
// Frame position tracking and sum store read-modify-write of the decimator.
module wfbd_accum import wfbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       pixel_valid,
  output logic       pixel_ready,
  input  in_word_t   pixel,
  output logic       job_valid,
  input  logic       job_ready,
  output blend_job_t job
);

  typedef enum logic [1:0] {MODE_FIRST, MODE_MID, MODE_LAST} mode_t;

  logic [ADDR_W-1:0]     byte_pos;
  logic [CFG_W-1:0]      frame_idx;
  logic                  s1_valid;
  mode_t                 s1_mode;
  logic [SAMPLE_W-1:0]   s1_sample;
  logic [ADDR_W-1:0]     s1_pos;
  logic                  s1_frame_end;
  logic                  byp_hit;
  logic [SUM_W-1:0]      byp_data;

  logic [CFG_W-1:0]      group;
  logic [CFG_W-1:0]      last_idx;
  mode_t                 in_mode;
  logic                  s1_go;
  logic                  accept;
  logic                  ram_we;
  logic [SUM_W-1:0]      ram_rdata;
  logic [SUM_W-1:0]      old_sum;
  logic [SUM_W-1:0]      new_sum;
  logic [2*CFG_W-1:0]    product;

  // Group size, with lapse factors below two acting as two
  assign group    = (cfg.lapse_factor < MIN_GROUP) ? MIN_GROUP : cfg.lapse_factor;
  assign last_idx = group - CFG_W'(1);

  always_comb begin
    if (frame_idx >= last_idx) begin
      in_mode = MODE_LAST;
    end else if (frame_idx == '0) begin
      in_mode = MODE_FIRST;
    end else begin
      in_mode = MODE_MID;
    end
  end

  // Non-final frames retire in stage one; final frames wait for the divider
  assign s1_go       = s1_valid && ((s1_mode != MODE_LAST) || job_ready);
  assign pixel_ready = !s1_valid || s1_go;
  assign accept      = pixel_valid && pixel_ready;
  assign ram_we      = s1_valid && (s1_mode != MODE_LAST);

  // Forward a write that collided with this word's read
  assign old_sum = byp_hit ? byp_data : ram_rdata;
  assign new_sum = (s1_mode == MODE_FIRST) ? SUM_W'(s1_sample)
                                           : old_sum + SUM_W'(s1_sample);
  assign product = s1_sample * cfg.primary_weight;

  assign job_valid     = s1_valid && (s1_mode == MODE_LAST);
  assign job.total     = old_sum + SUM_W'(product);
  assign job.divisor   = DIVISOR_W'(group) + DIVISOR_W'(cfg.primary_weight)
                         - DIVISOR_W'(1);
  assign job.frame_end = s1_frame_end;

  // Track position in frame and frame in group; advance stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos  <= '0;
      frame_idx <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (pixel.frame_end) begin
          byte_pos  <= '0;
          frame_idx <= (in_mode == MODE_LAST) ? '0 : frame_idx + CFG_W'(1);
        end else begin
          byte_pos <= byte_pos + ADDR_W'(1);
        end
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Load stage one payload and note a read that meets the pending write
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode      <= in_mode;
      s1_sample    <= pixel.sample;
      s1_pos       <= byte_pos;
      s1_frame_end <= pixel.frame_end;
      byp_hit      <= ram_we && (s1_pos == byte_pos);
      byp_data     <= new_sum;
    end
  end

  wfbd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (FRAME_BYTES)
  ) u_sum_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_pos),
    .wdata (new_sum),
    .re    (accept),
    .raddr (byte_pos),
    .rdata (ram_rdata)
  );

endmodule

FILE: hdl/wfbd_div.sv
// Pipelined restoring divider with saturation, two quotient bits per stage.
module wfbd_div import wfbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  blend_job_t job,
  output logic       blend_valid,
  input  logic       blend_ready,
  output out_word_t  blend
);

  typedef struct packed {
    logic [DIVISOR_W-1:0] rem;
    logic [QUO_W-1:0]     low;
    logic [QUO_W-1:0]     quo;
    logic [DIVISOR_W-1:0] divisor;
    logic                 sat;
    logic                 frame_end;
  } dstage_t;

  dstage_t         st [DIV_STAGES+1];
  logic [DIV_STAGES:0] v;
  logic [DIV_STAGES:0] rdy;

  // Split the sum; a high part not below the divisor means quotient over 255
  function automatic dstage_t div_load(blend_job_t j);
    dstage_t r;
    r.rem       = j.total[SUM_W-1:QUO_W];
    r.low       = j.total[QUO_W-1:0];
    r.quo       = '0;
    r.divisor   = j.divisor;
    r.sat       = (j.total[SUM_W-1:QUO_W] >= j.divisor);
    r.frame_end = j.frame_end;
    return r;
  endfunction

  // Shift in the next dividend bits and subtract where the divisor fits
  function automatic dstage_t div_step(dstage_t s);
    dstage_t           r;
    logic [DIVISOR_W:0] t;
    r = s;
    for (int i = 0; i < STEP_BITS; i++) begin
      t     = {r.rem, r.low[QUO_W-1]};
      r.low = {r.low[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, r.divisor}) begin
        r.rem = DIVISOR_W'(t - {1'b0, r.divisor});
        r.quo = {r.quo[QUO_W-2:0], 1'b1};
      end else begin
        r.rem = t[DIVISOR_W-1:0];
        r.quo = {r.quo[QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // A stage takes a word when it is empty or its word moves on
  always_comb begin
    rdy[DIV_STAGES] = !v[DIV_STAGES] || blend_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign job_ready = rdy[0];

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && job_valid) begin
      st[0] <= div_load(job);
    end
  end

  // Quotient stages
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v[k-1]) begin
        st[k] <= div_step(st[k-1]);
      end
    end
  end

  // Last stage doubles as the output register
  assign blend_valid         = v[DIV_STAGES];
  assign blend.blended       = st[DIV_STAGES].sat ? '1 : st[DIV_STAGES].quo;
  assign blend.out_frame_end = st[DIV_STAGES].frame_end;

endmodule

FILE: hdl/weighted_frame_blend_decimator.sv
// Top level of the weighted frame blend decimator: registers, accumulator, divider.
//
//  Channel  Direction  Handshake               Word
//  pixel    into       pixel_valid/ready       in_word_t  (sample, frame_end)
//  blend    out of     blend_valid/ready       out_word_t (blended, out_frame_end)
//  apb      into       psel/penable, pready=1  lapse_factor @0x0, primary_weight @0x4
//
//  One pixel word is taken every clock unless a last-frame word waits on the divider.
//  A blended word is offered after stage one (sum store read, multiply-add), the divider
//  entry stage and four quotient stages. Non-final frames retire at the store write.
//  rst clears positions, frame count and all valid bits; the sum store is not cleared.
//  A blend stall holds full divider stages and last-frame words; empty stages fill.
module weighted_frame_blend_decimator import wfbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  in_word_t              pixel,
  output logic                  blend_valid,
  input  logic                  blend_ready,
  output out_word_t             blend
);

  cfg_t       cfg;
  blend_job_t job;
  logic       job_valid;
  logic       job_ready;

  assign pready = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lapse_factor   <= LAPSE_RESET;
      cfg.primary_weight <= WEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_LAPSE:  cfg.lapse_factor   <= pwdata[CFG_W-1:0];
        REG_WEIGHT: cfg.primary_weight <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (paddr[2])
      REG_LAPSE:  prdata = APB_DATA_W'(cfg.lapse_factor);
      REG_WEIGHT: prdata = APB_DATA_W'(cfg.primary_weight);
      default:    prdata = '0;
    endcase
  end

  wfbd_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job)
  );

  wfbd_div u_div (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .blend_valid (blend_valid),
    .blend_ready (blend_ready),
    .blend       (blend)
  );

endmodule

FILE: hdl/wfbd_checker.sv
// Port-level checks of the frame blend decimator and their binding to the top level.
`include "weighted_frame_blend_decimator_defines.svh"

module wfbd_checker import wfbd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready,
  input logic                  pixel_ready,
  input logic                  blend_valid,
  input logic                  blend_ready,
  input out_word_t             blend
);

  // Hold a stalled blended word
  `WFBD_ASSERT(a_blend_hold, blend_valid && !blend_ready |=> blend_valid && $stable(blend), "blended word changed under stall")

  // With the output empty, no stage can be blocked
  `WFBD_ASSERT(a_ready_when_empty, !blend_valid |-> pixel_ready, "pixel word refused with empty output")

  // A written register reads back on the next cycle
  `WFBD_ASSERT(a_cfg_readback, (psel && penable && pwrite && pready) ##1 (psel && !pwrite && paddr[2] == $past(paddr[2])) |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]), "register read back differs from write")

  // Drop all output words on reset
  `WFBD_ASSERT_RST(a_reset_empty, rst |=> !blend_valid, "blended word valid after reset")

endmodule

bind weighted_frame_blend_decimator wfbd_checker u_wfbd_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the weighted frame blend decimator: predictor, stimulus, checks.
`timescale 1ns / 1ps

import wfbd_pkg::*;

// Predicts blended words from accepted pixel words and checks those the block emits
class blend_predictor;
  localparam int unsigned SUM_MASK = (1 << SUM_W) - 1;

  int unsigned sums[FRAME_BYTES];
  int unsigned byte_pos;
  int unsigned frame_idx;
  int unsigned lapse;
  int unsigned weight;
  int unsigned mismatches;
  out_word_t   expected_blends[$];

  function new();
    byte_pos   = 0;
    frame_idx  = 0;
    lapse      = LAPSE_RESET;
    weight     = WEIGHT_RESET;
    mismatches = 0;
  endfunction

  function void set_reg(logic idx, logic [APB_DATA_W-1:0] value);
    if (idx == REG_LAPSE) begin
      lapse = value[CFG_W-1:0];
    end else begin
      weight = value[CFG_W-1:0];
    end
  endfunction

  // Accumulate one pixel word and queue a blended word on the last frame of a group
  function void take_pixel(in_word_t w);
    int unsigned smp;
    int unsigned group;
    int unsigned total;
    int unsigned quo;
    out_word_t   res;
    smp   = w.sample;
    group = (lapse < MIN_GROUP) ? MIN_GROUP : lapse;
    if (frame_idx >= group - 1) begin
      total = (sums[byte_pos] + smp * weight) & SUM_MASK;
      quo   = total / (group + weight - 1);
      if (quo > 255) quo = 255;
      res.blended       = 8'(quo);
      res.out_frame_end = w.frame_end;
      expected_blends.push_back(res);
    end else if (frame_idx == 0) begin
      sums[byte_pos] = smp;
    end else begin
      sums[byte_pos] = (sums[byte_pos] + smp) & SUM_MASK;
    end
    // advance position and frame count
    if (w.frame_end) begin
      byte_pos  = 0;
      frame_idx = (frame_idx >= group - 1) ? 0 : ((frame_idx + 1) & 8'hFF);
    end else begin
      byte_pos = (byte_pos + 1) % FRAME_BYTES;
    end
  endfunction

  function void report(string what, out_word_t want, out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected blended=%0d end=%0b, got blended=%0d end=%0b",
               $realtime, what, want.blended, want.out_frame_end,
               got.blended, got.out_frame_end);
  endfunction

  function void check_blend(out_word_t got);
    out_word_t want;
    if (expected_blends.size() == 0) begin
      want = 'x;
      report("blend word with none expected", want, got);
      return;
    end
    want = expected_blends.pop_front();
    if (got.blended !== want.blended || got.out_frame_end !== want.out_frame_end)
      report("blend word mismatch", want, got);
  endfunction

  function int unsigned pending();
    return expected_blends.size();
  endfunction

  // Count words still owed at the end of the run
  function void close_out();
    if (expected_blends.size() != 0) begin
      $display("%0d blend words never arrived", expected_blends.size());
      mismatches += expected_blends.size();
    end
  endfunction
endclass

module testbench;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          END_WAIT      = 5000;
  localparam longint      TIMEOUT_NS    = 64'd10_000_000;
  localparam int unsigned SEG_ITEMS     = 90;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_ready;
  in_word_t              pixel       = '0;
  logic                  blend_valid;
  logic                  blend_ready = 1'b0;
  out_word_t             blend;

  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  blend_predictor sb;

  weighted_frame_blend_decimator DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .blend_valid (blend_valid),
    .blend_ready (blend_ready),
    .blend       (blend)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the blend side at random
  always @(posedge clk) begin
    blend_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Track register writes, accepted pixel words and emitted blend words
  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready) sb.set_reg(paddr[2], pwdata);
      if (pixel_valid && pixel_ready) sb.take_pixel(pixel);
      if (blend_valid && blend_ready) sb.check_blend(blend);
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // Offer one pixel word, with random gaps ahead of it, and hold until taken
  task automatic send_pixel(input logic [SAMPLE_W-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid     <= 1'b1;
    pixel.sample    <= value;
    pixel.frame_end <= last;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_pixel(pick_sample(), i == len - 1);
  endtask

  // Hold the sender until every blend word is in and the pipeline has emptied
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Send random frames, now and then changing a register between frames
  task automatic run_segment(input int unsigned target, input int unsigned max_len,
                             input int unsigned change_pct);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(max_len, 1);
      send_frame(len);
      sent += len;
      if ($urandom_range(99) < change_pct) begin
        if ($urandom_range(1) == 1) write_reg(REG_LAPSE, 8'($urandom_range(6)));
        else write_reg(REG_WEIGHT, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int unsigned  waited;
    logic [7:0]   lapse_val;
    logic [7:0]   weight_val;
    int unsigned  target;
    int unsigned  max_len;
    sb = new();
    send_idle_pct = 26;
    recv_idle_pct = 51;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: plain average of two frames, extremes of the sample
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd2, 1'b1);

    // Shrink the group mid-way with zero weight: quotient saturates
    write_reg(REG_LAPSE, 8'd3);
    write_reg(REG_WEIGHT, 8'd0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd3, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd4, 1'b1);
    write_reg(REG_LAPSE, 8'd0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd9, 1'b1);

    // Lapse factor of one acts as two, heaviest weight
    write_reg(REG_LAPSE, 8'd1);
    write_reg(REG_WEIGHT, 8'd255);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd200, 1'b1);

    // First frame of a group fills every store entry that the longest frame below reads
    write_reg(REG_LAPSE, 8'd2);
    write_reg(REG_WEIGHT, 8'd1);
    send_frame(12);
    send_frame(3);

    // Random frames over a range of settings and idling patterns
    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 0) begin
        send_idle_pct = 26;
        recv_idle_pct = 51;
      end else if (seg == 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 26;
      end else if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      lapse_val  = 8'($urandom_range(6));
      weight_val = 8'($urandom_range(255));
      target     = SEG_ITEMS;
      max_len    = 12;
      case (seg)
        0: begin
          lapse_val  = 8'd2;
          weight_val = 8'd1;
        end
        1: begin
          lapse_val  = 8'd255;
          weight_val = 8'd255;
          target     = 255;
          max_len    = 1;
        end
        2: begin
          lapse_val  = 8'd3;
          weight_val = 8'd0;
        end
        4: begin
          lapse_val  = 8'd2;
          weight_val = 8'd255;
        end
        6: lapse_val = 8'd1;
        8: begin
          lapse_val  = 8'd0;
          weight_val = 8'd0;
        end
        10: begin
          lapse_val  = 8'd5;
          weight_val = 8'd200;
        end
        default: ;
      endcase
      write_reg(REG_LAPSE, lapse_val);
      write_reg(REG_WEIGHT, weight_val);
      run_segment(target, max_len, (max_len == 1) ? 0 : 4);
    end

    // Drain and give a verdict
    pixel_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (sb.pending() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
